// ===== hdl/lzwd_pkg.sv =====
// Shared types and constants for the LZ77 window decompressor.
// Used by lzwd_ctrl, lzwd_dpath and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lzwd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 24;
  localparam int FLAG_BITS    = 8;
  localparam int FCNT_W       = 4;
  localparam int MLEN_W       = 5;
  localparam int MIN_MATCH    = 3;

  typedef enum logic [2:0] {
    ST_FLAG,
    ST_TOKEN,
    ST_MATCH2,
    ST_COPY_RD,
    ST_COPY_WR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_flags;
    logic save_first;
    logic start_match;
    logic lit_emit;
    logic copy_rd;
    logic copy_emit;
    logic next_tok;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tok_is_match;
    logic rem_zero;
    logic flags_one;
    logic slot_free;
    logic copy_end;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/lz77_window_decompressor.sv =====
// Top level of the LZ77 (LZ10 token format) window decompressor.
// Instantiates lzwd_ctrl and lzwd_dpath; uses lzwd_pkg.
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    in_tdata[7:0] = packed_byte
//   out_     out  out_tvalid/out_tready  out_tdata[7:0] = out_byte, out_tlast = last
//   cfg_     in   cfg_we                 cfg_wdata[23:0] = output_length
//
// Flag, literal and first match beats are taken back to back while the output
// register is free; a literal is loaded into it as it is accepted. A match copies
// each byte as a history read, then a write and emit, for up to 18 bytes per token.
// Reset is synchronous, active low; history contents are not cleared.
// A stalled output holds the parser and the copy loop until the beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module lz77_window_decompressor (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [lzwd_pkg::LEN_W-1:0] cfg_wdata,   // output_length
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,    // [7:0] packed_byte
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [7:0]                      out_tdata,   // [7:0] out_byte
  output logic                            out_tlast
);

  lzwd_pkg::cmd_t cmd;
  lzwd_pkg::sts_t sts;

  lzwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lzwd_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/lzwd_ctrl.sv =====
// Parser and copy sequencer for the LZ77 window decompressor.
// Depends on lzwd_pkg; drives lzwd_dpath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module lzwd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire lzwd_pkg::sts_t sts,
  output lzwd_pkg::cmd_t     cmd
);

  lzwd_pkg::state_t state_r, state_nxt;
  logic accept;
  logic take;

  assign in_tready = ((state_r == lzwd_pkg::ST_FLAG) || (state_r == lzwd_pkg::ST_TOKEN) ||
                      (state_r == lzwd_pkg::ST_MATCH2)) && sts.slot_free;
  assign accept = in_tvalid && in_tready;
  // Beats that arrive after the stream has finished are consumed and dropped.
  assign take = accept && !sts.rem_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzwd_pkg::ST_FLAG;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lzwd_pkg::ST_FLAG: begin
        if (take) state_nxt = lzwd_pkg::ST_TOKEN;
      end
      lzwd_pkg::ST_TOKEN: begin
        if (take) begin
          if (sts.tok_is_match) state_nxt = lzwd_pkg::ST_MATCH2;
          else state_nxt = sts.flags_one ? lzwd_pkg::ST_FLAG : lzwd_pkg::ST_TOKEN;
        end
      end
      lzwd_pkg::ST_MATCH2: begin
        if (take) state_nxt = lzwd_pkg::ST_COPY_RD;
      end
      lzwd_pkg::ST_COPY_RD: begin
        state_nxt = lzwd_pkg::ST_COPY_WR;
      end
      lzwd_pkg::ST_COPY_WR: begin
        if (sts.slot_free) begin
          if (sts.copy_end) state_nxt = sts.flags_one ? lzwd_pkg::ST_FLAG : lzwd_pkg::ST_TOKEN;
          else state_nxt = lzwd_pkg::ST_COPY_RD;
        end
      end
      default: state_nxt = lzwd_pkg::ST_FLAG;
    endcase
    if (cfg_we) state_nxt = lzwd_pkg::ST_FLAG;
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      lzwd_pkg::ST_FLAG: begin
        cmd.load_flags = take;
      end
      lzwd_pkg::ST_TOKEN: begin
        cmd.save_first = take && sts.tok_is_match;
        cmd.lit_emit   = take && !sts.tok_is_match;
        cmd.next_tok   = take && !sts.tok_is_match;
      end
      lzwd_pkg::ST_MATCH2: begin
        cmd.start_match = take;
      end
      lzwd_pkg::ST_COPY_RD: begin
        cmd.copy_rd = 1'b1;
      end
      lzwd_pkg::ST_COPY_WR: begin
        cmd.copy_emit = sts.slot_free;
        cmd.next_tok  = sts.slot_free && sts.copy_end;
      end
      default: cmd = '0;
    endcase
  end

  a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzwd_pkg::ST_COPY_RD) && !cfg_we |=> (state_r == lzwd_pkg::ST_COPY_WR))
    else $error("copy read not followed by copy write");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_flags, cmd.save_first, cmd.start_match, cmd.lit_emit, cmd.copy_emit}))
    else $error("more than one datapath action in a cycle");

  a_copy_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzwd_pkg::ST_COPY_WR) && sts.slot_free && sts.copy_end && !cfg_we
    |=> (state_r == lzwd_pkg::ST_FLAG) || (state_r == lzwd_pkg::ST_TOKEN))
    else $error("match copy did not return to parsing");

endmodule

`default_nettype wire

// ===== hdl/lzwd_dpath.sv =====
// Datapath of the LZ77 window decompressor: token flags, match registers,
// byte counter, 4096-byte history memory and the output register. Uses lzwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lzwd_dpath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lzwd_pkg::LEN_W-1:0]     cfg_wdata,
  input  wire logic [lzwd_pkg::BYTE_W-1:0]    in_byte,
  input  wire lzwd_pkg::cmd_t                 cmd,
  output lzwd_pkg::sts_t                      sts,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [lzwd_pkg::BYTE_W-1:0]         out_tdata,
  output logic                                out_tlast
);

  logic [lzwd_pkg::BYTE_W-1:0]    hist_mem [lzwd_pkg::WINDOW_DEPTH];
  logic [lzwd_pkg::BYTE_W-1:0]    rd_data_r;
  logic [lzwd_pkg::WIN_AW-1:0]    ptr_r;
  logic [lzwd_pkg::WIN_AW-1:0]    dist_r;
  logic [lzwd_pkg::MLEN_W-1:0]    len_r;
  logic [lzwd_pkg::LEN_W-1:0]     rem_r;
  logic [lzwd_pkg::FLAG_BITS-1:0] flags_r;
  logic [lzwd_pkg::FCNT_W-1:0]    fcnt_r;
  logic [lzwd_pkg::BYTE_W-1:0]    first_r;
  logic                           out_valid_r;
  logic [lzwd_pkg::BYTE_W-1:0]    out_data_r;
  logic                           out_last_r;
  logic                           emit;
  logic [lzwd_pkg::BYTE_W-1:0]    emit_byte;
  logic [lzwd_pkg::WIN_AW-1:0]    rd_addr;

  assign emit      = cmd.lit_emit || cmd.copy_emit;
  assign emit_byte = cmd.lit_emit ? in_byte : rd_data_r;
  // The stored distance is one less than the real one, so one more is taken off.
  assign rd_addr   = ptr_r - dist_r - lzwd_pkg::WIN_AW'(1);

  assign sts.tok_is_match = flags_r[lzwd_pkg::FLAG_BITS-1];
  assign sts.rem_zero     = (rem_r == '0);
  assign sts.flags_one    = (fcnt_r <= lzwd_pkg::FCNT_W'(1));
  assign sts.slot_free    = !out_valid_r || out_tready;
  assign sts.copy_end     = (len_r == lzwd_pkg::MLEN_W'(1)) || (rem_r == lzwd_pkg::LEN_W'(1));

  always_ff @(posedge clk) begin
    if (emit) hist_mem[ptr_r] <= emit_byte;
    if (cmd.copy_rd) rd_data_r <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      rem_r       <= '0;
      flags_r     <= '0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        ptr_r <= ptr_r + lzwd_pkg::WIN_AW'(1);
        rem_r <= rem_r - lzwd_pkg::LEN_W'(1);
      end
      if (cmd.load_flags) begin
        flags_r <= in_byte;
        fcnt_r  <= lzwd_pkg::FCNT_W'(lzwd_pkg::FLAG_BITS);
      end else if (cmd.next_tok) begin
        flags_r <= {flags_r[lzwd_pkg::FLAG_BITS-2:0], 1'b0};
        if (fcnt_r != '0) fcnt_r <= fcnt_r - lzwd_pkg::FCNT_W'(1);
      end
      if (cfg_we) begin
        rem_r   <= cfg_wdata;
        flags_r <= '0;
        fcnt_r  <= '0;
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_first) first_r <= in_byte;
    if (cmd.start_match) begin
      dist_r <= {first_r[3:0], in_byte};
      len_r  <= lzwd_pkg::MLEN_W'(lzwd_pkg::MIN_MATCH) + lzwd_pkg::MLEN_W'(first_r[7:4]);
    end else if (cmd.copy_emit) begin
      len_r <= len_r - lzwd_pkg::MLEN_W'(1);
    end
    if (emit) begin
      out_data_r <= emit_byte;
      out_last_r <= (rem_r == lzwd_pkg::LEN_W'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_tready))
    else $error("output register loaded while a beat is still waiting");

  a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !cfg_we |=> (ptr_r == $past(ptr_r) + lzwd_pkg::WIN_AW'(1)))
    else $error("history pointer did not advance on an emitted byte");

  a_len_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_emit |-> (len_r != '0))
    else $error("match copy ran past its length");

endmodule

`default_nettype wire
